@@ rtl/kwmq_pkg.sv @@
// Shared types and constants for the k-way merge block built on a 4-ary max heap.
// Holds the heap entry layout, controller states, read selects and the command
// and status structs that join the controller and the datapath. No dependencies.
package kwmq_pkg;

    localparam int VAL_W       = 31;
    localparam int LIST_W      = 6;
    localparam int CFG_W       = 7;
    localparam int ARITY       = 4;
    localparam int LISTS_DEF   = 64;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 40;
    localparam int APB_DW      = 32;
    localparam int APB_AW      = 3;

    localparam logic [CFG_W-1:0] ACTIVE_RESET = 7'd64;

    // Operation codes carried on s_tuser.
    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_REFILL = 1'b1;

    // Register index as seen on paddr[2].
    localparam logic REG_ACTIVE_LISTS = 1'b0;

    typedef struct packed {
        logic [VAL_W-1:0]  val;
        logic [LIST_W-1:0] src;
    } slot_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_BSTART,
        ST_BKEY,
        ST_BKEYRD,
        ST_PICK,
        ST_CMP,
        ST_PLACE,
        ST_BNEXT,
        ST_EMIT
    } state_t;

    typedef enum logic [2:0] {
        RD_IDLE,
        RD_ROOT_KIDS,
        RD_NODE_KIDS,
        RD_BEST_KIDS,
        RD_NODE_SLOT
    } rd_kind_t;

    typedef struct packed {
        logic     take;
        logic     load_wr;
        logic     refill_key;
        logic     node_init;
        logic     node_dec;
        logic     key_from_node;
        logic     pick;
        logic     wr_key;
        logic     wr_best;
        logic     descend;
        logic     emit;
        rd_kind_t rd_kind;
    } cmd_t;

    typedef struct packed {
        logic op_refill;
        logic idx_ok;
        logic cnt_hit;
        logic n_ge2;
        logic key_wins;
        logic best_has_kids;
        logic node_zero;
        logic out_free;
    } sts_t;

endpackage

@@ rtl/kwmq_ctrl.sv @@
// Controller of the k-way merge block: sequences loads, the bottom-up heap
// build and each sift-down level. Depends on kwmq_pkg; drives kwmq_dp by commands.
module kwmq_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  kwmq_pkg::sts_t   sts,
    output kwmq_pkg::cmd_t   cmd
);
    import kwmq_pkg::*;

    state_t state_reg, state_next;
    logic   building_reg, building_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            building_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            building_reg <= building_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        building_next = building_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) state_next = ST_DECODE;
            end
            ST_DECODE: begin
                if (sts.op_refill) begin
                    state_next = sts.n_ge2 ? ST_PICK : ST_PLACE;
                end else if (!sts.idx_ok) begin
                    state_next = ST_IDLE;
                end else if (sts.cnt_hit) begin
                    building_next = sts.n_ge2;
                    state_next    = sts.n_ge2 ? ST_BSTART : ST_EMIT;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_BSTART: state_next = ST_BKEY;
            ST_BKEY:   state_next = ST_BKEYRD;
            ST_BKEYRD: state_next = ST_PICK;
            ST_PICK:   state_next = ST_CMP;
            ST_CMP: begin
                if (sts.key_wins) begin
                    state_next = building_reg ? ST_BNEXT : ST_EMIT;
                end else begin
                    state_next = sts.best_has_kids ? ST_PICK : ST_PLACE;
                end
            end
            ST_PLACE: state_next = building_reg ? ST_BNEXT : ST_EMIT;
            ST_BNEXT: begin
                if (sts.node_zero) begin
                    building_next = 1'b0;
                    state_next    = ST_EMIT;
                end else begin
                    state_next = ST_BKEY;
                end
            end
            ST_EMIT: begin
                if (sts.out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                cmd.take = s_tvalid;
            end
            ST_DECODE: begin
                if (sts.op_refill) begin
                    cmd.refill_key = 1'b1;
                    if (sts.n_ge2) cmd.rd_kind = RD_ROOT_KIDS;
                end else if (sts.idx_ok) begin
                    cmd.load_wr = 1'b1;
                end
            end
            ST_BSTART: cmd.node_init = 1'b1;
            ST_BKEY: begin
                if (!sts.node_zero) cmd.rd_kind = RD_NODE_SLOT;
            end
            ST_BKEYRD: begin
                cmd.key_from_node = 1'b1;
                cmd.rd_kind       = RD_NODE_KIDS;
            end
            ST_PICK: cmd.pick = 1'b1;
            ST_CMP: begin
                if (sts.key_wins) begin
                    cmd.wr_key = 1'b1;
                end else begin
                    // The child moves up while the next row of children is fetched.
                    cmd.wr_best = 1'b1;
                    cmd.descend = 1'b1;
                    if (sts.best_has_kids) cmd.rd_kind = RD_BEST_KIDS;
                end
            end
            ST_PLACE: cmd.wr_key = 1'b1;
            ST_BNEXT: begin
                if (!sts.node_zero) cmd.node_dec = 1'b1;
            end
            ST_EMIT: cmd.emit = sts.out_free;
            default: cmd = '0;
        endcase
    end

`ifndef SYNTHESIS
    a_pick_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_PICK) |-> ($past(state_reg) == ST_DECODE ||
                                    $past(state_reg) == ST_BKEYRD ||
                                    $past(state_reg) == ST_CMP))
        else $error("child pick entered without a children read");
    a_accept_decode: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == ST_DECODE))
        else $error("accepted word not decoded");
`endif

endmodule

@@ rtl/kwmq_dp.sv @@
// Datapath of the k-way merge block: heap root register, banked child memory,
// sift-down compare unit, load counter and output register. Depends on kwmq_pkg.
module kwmq_dp #(
    parameter int LISTS = kwmq_pkg::LISTS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [kwmq_pkg::CFG_W-1:0]    active_lists,
    input  logic                          in_op,
    input  logic [kwmq_pkg::LIST_W-1:0]   in_list,
    input  logic [kwmq_pkg::VAL_W-1:0]    in_value,
    input  kwmq_pkg::cmd_t                cmd,
    output kwmq_pkg::sts_t                sts,
    input  logic                          m_tready,
    output logic                          m_tvalid,
    output logic [kwmq_pkg::VAL_W-1:0]    top_value,
    output logic [kwmq_pkg::LIST_W-1:0]   top_list,
    output logic                          merge_done
);
    import kwmq_pkg::*;

    localparam int AW   = $clog2(LISTS);
    localparam int ROWS = (LISTS + ARITY - 2) / ARITY;
    localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int XW   = (AW + 3 > CFG_W) ? AW + 3 : CFG_W;

    // Slot 0 lives in root_reg. Slot s > 0 sits in bank (s-1)%4, row (s-1)/4,
    // so the four children of node p fill row p across the banks.
    slot_t bank_mem [ARITY][ROWS];
    slot_t rd_reg   [ARITY];

    slot_t             root_reg, key_reg, best_reg;
    logic [AW-1:0]     pos_reg, node_reg, best_pos_reg;
    logic [CFG_W-1:0]  cnt_reg;
    logic              in_op_reg;
    logic [LIST_W-1:0] in_list_reg;
    logic [VAL_W-1:0]  in_val_reg;
    logic              out_valid_reg;
    logic [VAL_W-1:0]  out_val_reg;
    logic [LIST_W-1:0] out_list_reg;
    logic              out_done_reg;

    logic [XW-1:0]     act_x, n_x, pos_x, best_kid_x, node_sm1, wr_sm1;
    logic [XW-1:0]     kid_x [ARITY];
    slot_t             kid_slot [ARITY];
    logic [CFG_W-1:0]  cnt_inc;
    logic [1:0]        lo_idx, hi_idx, best_idx, node_bank, wr_bank;
    slot_t             lo_s, hi_s, best_s, wr_data;
    logic [AW-1:0]     best_pos_new, node_first, wr_slot;
    logic [RW-1:0]     rd_row, node_row, wr_row;
    logic              wr_en, wr_root, wr_mem;

    always_comb begin
        act_x = (active_lists == '0) ? XW'(1) : XW'(active_lists);
        n_x   = (act_x > XW'(LISTS)) ? XW'(LISTS) : act_x;
    end

    assign cnt_inc = cnt_reg + CFG_W'(1);
    assign pos_x   = XW'(pos_reg);

    always_comb begin
        for (int b = 0; b < ARITY; b++) begin
            kid_x[b]    = (pos_x << 2) + XW'(b + 1);
            kid_slot[b] = (kid_x[b] < n_x) ? rd_reg[b] : '0;
        end
        // Pairwise compares keep the first of equal values.
        lo_idx   = (kid_slot[1].val > kid_slot[0].val) ? 2'd1 : 2'd0;
        hi_idx   = (kid_slot[3].val > kid_slot[2].val) ? 2'd3 : 2'd2;
        lo_s     = kid_slot[lo_idx];
        hi_s     = kid_slot[hi_idx];
        best_idx = (hi_s.val > lo_s.val) ? hi_idx : lo_idx;
        best_s   = (hi_s.val > lo_s.val) ? hi_s : lo_s;
    end

    assign best_pos_new = AW'(kid_x[best_idx]);
    assign best_kid_x   = (XW'(best_pos_reg) << 2) + XW'(1);
    assign node_first   = AW'((n_x - XW'(2)) >> 2);
    assign node_sm1     = XW'(node_reg) - XW'(1);
    assign node_bank    = node_sm1[1:0];
    assign node_row     = RW'(node_sm1 >> 2);

    always_comb begin
        sts.op_refill     = (in_op_reg == OP_REFILL);
        sts.idx_ok        = XW'(in_list_reg) < n_x;
        sts.cnt_hit       = XW'(cnt_inc) >= n_x;
        sts.n_ge2         = n_x >= XW'(2);
        sts.key_wins      = key_reg.val >= best_reg.val;
        sts.best_has_kids = best_kid_x < n_x;
        sts.node_zero     = (node_reg == '0);
        sts.out_free      = !out_valid_reg || m_tready;
    end

    always_comb begin
        unique case (cmd.rd_kind)
            RD_IDLE:      rd_row = '0;
            RD_ROOT_KIDS: rd_row = '0;
            RD_NODE_KIDS: rd_row = RW'(node_reg);
            RD_BEST_KIDS: rd_row = RW'(best_pos_reg);
            RD_NODE_SLOT: rd_row = node_row;
            default:      rd_row = '0;
        endcase
    end

    always_comb begin
        wr_en   = cmd.load_wr || cmd.wr_key || cmd.wr_best;
        wr_slot = cmd.load_wr ? AW'(in_list_reg) : pos_reg;
        priority if (cmd.load_wr) begin
            wr_data = '{val: in_val_reg, src: in_list_reg};
        end else if (cmd.wr_best) begin
            wr_data = best_reg;
        end else begin
            wr_data = key_reg;
        end
        wr_sm1  = XW'(wr_slot) - XW'(1);
        wr_bank = wr_sm1[1:0];
        wr_row  = RW'(wr_sm1 >> 2);
        wr_root = wr_en && (wr_slot == '0);
        wr_mem  = wr_en && (wr_slot != '0);
    end

    always_ff @(posedge aclk) begin
        if (wr_mem) bank_mem[wr_bank][wr_row] <= wr_data;
    end

    always_ff @(posedge aclk) begin
        if (cmd.rd_kind != RD_IDLE) begin
            for (int b = 0; b < ARITY; b++) begin
                rd_reg[b] <= bank_mem[b][rd_row];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.take) begin
            in_op_reg   <= in_op;
            in_list_reg <= in_list;
            in_val_reg  <= in_value;
        end
        if (wr_root) root_reg <= wr_data;
        if (cmd.refill_key) begin
            key_reg <= '{val: in_val_reg, src: root_reg.src};
            pos_reg <= '0;
        end else if (cmd.key_from_node) begin
            key_reg <= sts.node_zero ? root_reg : rd_reg[node_bank];
            pos_reg <= node_reg;
        end else if (cmd.descend) begin
            pos_reg <= best_pos_reg;
        end
        if (cmd.pick) begin
            best_reg     <= best_s;
            best_pos_reg <= best_pos_new;
        end
        if (cmd.node_init) begin
            node_reg <= node_first;
        end else if (cmd.node_dec) begin
            node_reg <= node_reg - AW'(1);
        end
        if (cmd.emit) begin
            out_val_reg  <= root_reg.val;
            out_list_reg <= root_reg.src;
            out_done_reg <= (root_reg.val == '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.load_wr) cnt_reg <= sts.cnt_hit ? '0 : cnt_inc;
            if (cmd.emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign top_value  = out_val_reg;
    assign top_list   = out_list_reg;
    assign merge_done = out_done_reg;

`ifndef SYNTHESIS
    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> (!out_valid_reg || m_tready))
        else $error("result overwrote a word not yet taken");
    a_descend_deeper: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.descend |=> (pos_reg > $past(pos_reg)))
        else $error("sift-down did not move to a deeper slot");
    a_best_larger: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.wr_best |-> (best_reg.val > key_reg.val))
        else $error("child moved up without being strictly larger");
`endif

endmodule

@@ rtl/kway_merge_quaternary_heap.sv @@
// Top level of the k-way merge block: stream ports, configuration port and the
// instances of kwmq_ctrl and kwmq_dp. Depends on kwmq_pkg.
//
// Merges up to LISTS descending lists, each ended by zero, into one descending
// stream through a 4-ary max heap. Load words (s_tuser = 0) write a list head;
// the load that completes active_lists builds the heap and emits the root.
// Refill words (s_tuser = 1) replace the root value, sift it down and emit the
// new root; m_tuser flags that the root value is zero. One word is in work at a
// time. A refill descends L levels (at most 3 for 64 lists); each level is a
// select step on a prefetched four-wide child row and a compare-and-write step
// that also fetches the next row, and a key that settles in a leaf takes an
// extra write step. A load that completes active_lists with more than one list
// sifts down every interior node of the build the same way before the root is
// emitted. A result waits until the output register is free.
// The register active_lists lies at byte address 0 and resets to 64.
module kway_merge_quaternary_heap #(
    parameter int LISTS = kwmq_pkg::LISTS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // s_tdata: list_index[5:0], value[36:6], zero fill [39:37]
    input  logic [kwmq_pkg::IN_TDATA_W-1:0]     s_tdata,
    // s_tuser: operation[0]
    input  logic                                s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // m_tdata: top_value[30:0], top_list[36:31], zero fill [39:37]
    output logic [kwmq_pkg::OUT_TDATA_W-1:0]    m_tdata,
    // m_tuser: merge_done[0]
    output logic                                m_tuser,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [kwmq_pkg::APB_AW-1:0]         paddr,
    input  logic [kwmq_pkg::APB_DW-1:0]         pwdata,
    output logic [kwmq_pkg::APB_DW-1:0]         prdata,
    output logic                                pready
);
    import kwmq_pkg::*;

    logic [CFG_W-1:0]  active_reg;
    cmd_t              cmd;
    sts_t              sts;
    logic [VAL_W-1:0]  top_value;
    logic [LIST_W-1:0] top_list;
    logic              merge_done;

    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= ACTIVE_RESET;
        end else if (psel && penable && pwrite && pready && (paddr[2] == REG_ACTIVE_LISTS)) begin
            active_reg <= pwdata[CFG_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_ACTIVE_LISTS) ? APB_DW'(active_reg) : '0;

    kwmq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    kwmq_dp #(
        .LISTS (LISTS)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .active_lists (active_reg),
        .in_op        (s_tuser),
        .in_list      (s_tdata[LIST_W-1:0]),
        .in_value     (s_tdata[LIST_W+VAL_W-1:LIST_W]),
        .cmd          (cmd),
        .sts          (sts),
        .m_tready     (m_tready),
        .m_tvalid     (m_tvalid),
        .top_value    (top_value),
        .top_list     (top_list),
        .merge_done   (merge_done)
    );

    assign m_tdata = {(OUT_TDATA_W-VAL_W-LIST_W)'(0), top_list, top_value};
    assign m_tuser = merge_done;

endmodule

@@ tb/tb_kway_merge_quaternary_heap.sv @@
// Self-checking testbench for kway_merge_quaternary_heap: feeds load and refill words
// under random idling on both stream sides and checks every merged word against a
// built-in 4-ary heap predictor. Depends on kwmq_pkg and the kway_merge_quaternary_heap RTL.
`timescale 1ns / 1ps

module tb_kway_merge_quaternary_heap;
    import kwmq_pkg::*;

    localparam int LISTS       = LISTS_DEF;
    localparam int SETTLE      = 16;
    localparam int HOLD_CYCLES = 400;
    localparam int IDLE_LIMIT  = 4000;
    localparam int PHASE_WORDS = 50;
    localparam int PLAN_LEN    = 10;
    localparam logic [CFG_W-1:0] ACTIVE_PLAN [PLAN_LEN] =
        '{7'd1, 7'd0, 7'd64, 7'd2, 7'd17, 7'd127, 7'd5, 7'd3, 7'd13, 7'd100};

    typedef struct packed {
        logic [VAL_W-1:0]  value;
        logic [LIST_W-1:0] list;
        logic              done;
    } merge_top_t;

    typedef enum int unsigned {RX_OPEN, RX_MOSTLY, RX_SPARSE, RX_SHUT} rx_mode_t;

    class merge_tracker;
        slot_t            heap_slots[LISTS];
        bit               written[LISTS];
        logic [CFG_W-1:0] active_reg;
        logic [CFG_W-1:0] loads_seen;
        int unsigned      builds;
        int unsigned      mismatch_count;
        merge_top_t       pending_tops[$];

        function new();
            foreach (heap_slots[i]) begin
                heap_slots[i] = '0;
                written[i] = 1'b0;
            end
            active_reg = ACTIVE_RESET;
            loads_seen = '0;
            builds = 0;
            mismatch_count = 0;
        endfunction

        function int unsigned live_count();
            if (active_reg == 0) return 1;
            if (active_reg > LISTS) return LISTS;
            return 32'(active_reg);
        endfunction

        function int unsigned unwritten(int unsigned n);
            int unsigned cnt;
            cnt = 0;
            for (int unsigned i = 0; i < n; i++) if (!written[i]) cnt++;
            return cnt;
        endfunction

        // Slots at or past the active count behave as empty entries.
        function slot_t peek_slot(int unsigned idx, int unsigned n);
            if (idx >= n) return '0;
            return heap_slots[idx];
        endfunction

        function void settle_slot(int unsigned pos, int unsigned n);
            slot_t       key, best, kid;
            int unsigned first, best_pos;
            key = heap_slots[pos];
            forever begin
                first = pos * ARITY + 1;
                if (first >= n) break;
                best_pos = first;
                best = peek_slot(first, n);
                // Strict compare keeps the first of equal children.
                for (int unsigned k = 1; k < ARITY; k++) begin
                    kid = peek_slot(first + k, n);
                    if (kid.val > best.val) begin
                        best = kid;
                        best_pos = first + k;
                    end
                end
                if (key.val >= best.val) break;
                heap_slots[pos] = best;
                pos = best_pos;
            end
            heap_slots[pos] = key;
        endfunction

        function void take_word(logic op, logic [LIST_W-1:0] idx, logic [VAL_W-1:0] value);
            int unsigned n;
            n = live_count();
            if (op == OP_LOAD) begin
                if (idx >= n) return;
                heap_slots[idx] = '{val: value, src: idx};
                written[idx] = 1'b1;
                loads_seen = loads_seen + 1'b1;
                if (loads_seen < n) return;
                loads_seen = '0;
                builds++;
                if (n >= 2) begin
                    for (int unsigned i = (n - 2) / ARITY + 1; i > 0; i--) settle_slot(i - 1, n);
                end
            end else begin
                heap_slots[0].val = value;
                settle_slot(0, n);
            end
            pending_tops.push_back('{value: heap_slots[0].val, list: heap_slots[0].src,
                                     done: (heap_slots[0].val == '0)});
        endfunction

        task flag_mismatch(string msg);
            if (mismatch_count < 50) $display("[%0t] mismatch: %s", $realtime, msg);
            mismatch_count++;
        endtask

        task check_top(logic [OUT_TDATA_W-1:0] tdata, logic tuser);
            merge_top_t want;
            if (pending_tops.size() == 0) begin
                flag_mismatch($sformatf("merged word %h arrived with nothing expected", tdata));
                return;
            end
            want = pending_tops.pop_front();
            if (tdata[VAL_W-1:0] !== want.value)
                flag_mismatch($sformatf("top_value %0d, expected %0d",
                                        tdata[VAL_W-1:0], want.value));
            if (tdata[VAL_W +: LIST_W] !== want.list)
                flag_mismatch($sformatf("top_list %0d, expected %0d",
                                        tdata[VAL_W +: LIST_W], want.list));
            if (tuser !== want.done)
                flag_mismatch($sformatf("merge_done %b, expected %b", tuser, want.done));
        endtask
    endclass

    logic                    aclk     = 1'b0;
    logic                    aresetn  = 1'b0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [IN_TDATA_W-1:0]   s_tdata  = '0;
    logic                    s_tuser  = 1'b0;
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]  m_tdata;
    logic                    m_tuser;
    logic                    psel     = 1'b0;
    logic                    penable  = 1'b0;
    logic                    pwrite   = 1'b0;
    logic [APB_AW-1:0]       paddr    = '0;
    logic [APB_DW-1:0]       pwdata   = '0;
    logic [APB_DW-1:0]       prdata;
    logic                    pready;

    bit           hold_off_req = 1'b0;
    bit           tie_run      = 1'b0;
    int unsigned  burst_left   = 0;
    int unsigned  word_count   = 0;
    int unsigned  list_cur[LISTS];
    int unsigned  list_left[LISTS];
    merge_tracker tracker      = new();

    kway_merge_quaternary_heap #(.LISTS(LISTS)) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) tracker.check_top(m_tdata, m_tuser);
    end

    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable && pready))
                quiet = 0;
            else
                quiet++;
        end
        $display("** kway_merge_quaternary_heap: FAILED **");
        $finish;
    end

    // The receiver switches among random stall patterns; on request it
    // shuts for a long stretch so that the block backs up into its input.
    initial begin : receiver
        int unsigned stretch;
        rx_mode_t    mode;
        stretch = 0;
        mode = RX_OPEN;
        forever begin
            @(negedge aclk);
            if (hold_off_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_off_req = 1'b0;
            end
            if (stretch == 0) begin
                stretch = $urandom_range(4, 40);
                mode = rx_mode_t'($urandom_range(0, 3));
            end
            stretch--;
            case (mode)
                RX_OPEN: begin
                    m_tready <= 1'b1;
                end
                RX_MOSTLY: begin
                    m_tready <= ($urandom_range(0, 3) != 0);
                end
                RX_SPARSE: begin
                    m_tready <= ($urandom_range(0, 3) == 0);
                end
                default: begin
                    m_tready <= 1'b0;
                end
            endcase
        end
    end

    // Called at a falling edge; returns at the falling edge after the word is taken.
    task automatic send_word(logic op, logic [LIST_W-1:0] idx, logic [VAL_W-1:0] value);
        int unsigned gap;
        if (op == OP_REFILL || idx < tracker.live_count()) word_count++;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {{(IN_TDATA_W - VAL_W - LIST_W){1'b0}}, value, idx};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        tracker.take_word(op, idx, value);
        @(negedge aclk);
    endtask

    task automatic drain_block();
        s_tvalid <= 1'b0;
        while (tracker.pending_tops.size() != 0) @(negedge aclk);
        // A load that completes nothing may still be in work.
        repeat (SETTLE) @(negedge aclk);
    endtask

    task automatic apb_access(logic wr, logic [CFG_W-1:0] wdata, output logic [APB_DW-1:0] rdata);
        psel   <= 1'b1;
        pwrite <= wr;
        paddr  <= {REG_ACTIVE_LISTS, 2'b00};
        pwdata <= {{(APB_DW - CFG_W){1'b0}}, wdata};
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        rdata = prdata;
        if (wr) tracker.active_reg = wdata;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic configure(logic [CFG_W-1:0] count);
        logic [APB_DW-1:0] rd;
        drain_block();
        apb_access(1'b1, count, rd);
        apb_access(1'b0, '0, rd);
        if (rd !== {{(APB_DW - CFG_W){1'b0}}, count})
            tracker.flag_mismatch($sformatf("active_lists reads %0d, written %0d", rd, count));
    endtask

    function automatic logic [VAL_W-1:0] fresh_head(int unsigned l);
        int unsigned pick;
        pick = $urandom_range(0, 7);
        list_left[l] = (tracker.live_count() > 16) ? $urandom_range(0, 1) : $urandom_range(0, 5);
        if (pick == 0) list_cur[l] = 0;
        else if (tie_run) list_cur[l] = $urandom_range(1, 6);
        else if (pick == 1) list_cur[l] = 32'h7FFF_FFFF;
        else list_cur[l] = $urandom_range(1, 32'h7FFF_FFFF);
        return VAL_W'(list_cur[l]);
    endfunction

    function automatic logic [VAL_W-1:0] next_in_list(int unsigned l);
        if (list_left[l] == 0 || list_cur[l] == 0) begin
            list_cur[l] = 0;
        end else begin
            list_left[l]--;
            if (tie_run) begin
                if (list_cur[l] > 1) list_cur[l] -= $urandom_range(0, 1);
            end else if (list_cur[l] > 1) begin
                list_cur[l] = $urandom_range(1, list_cur[l] - 1);
            end else begin
                list_cur[l] = 0;
            end
        end
        return VAL_W'(list_cur[l]);
    endfunction

    // One merge: load every active list head in random order, with some ignored,
    // repeated and early refill words mixed in, then refill until the merge is done.
    // A build must never see a slot that was not written since reset, so the number
    // of unwritten slots is kept at or below the loads still needed for the build.
    task automatic merge_run();
        int unsigned n, p, j, tmp, first_build, pick;
        int unsigned order[LISTS];
        logic [LIST_W-1:0] idx;
        logic [VAL_W-1:0]  v;
        n = tracker.live_count();
        tie_run = ($urandom_range(0, 3) == 0);
        for (int unsigned k = 0; k < n; k++) order[k] = k;
        for (int unsigned k = n - 1; k > 0; k--) begin
            j = $urandom_range(0, k);
            tmp = order[k];
            order[k] = order[j];
            order[j] = tmp;
        end
        p = 0;
        first_build = tracker.builds;
        while (tracker.builds == first_build) begin
            pick = $urandom_range(0, 15);
            if (pick == 0 && n < LISTS) begin
                send_word(OP_LOAD, LIST_W'($urandom_range(n, LISTS - 1)),
                          VAL_W'($urandom_range(0, 32'h7FFF_FFFF)));
            end else if (pick == 1 && tracker.unwritten(n) == 0) begin
                send_word(OP_REFILL, LIST_W'($urandom_range(0, LISTS - 1)),
                          VAL_W'($urandom_range(0, 32'h7FFF_FFFF)));
            end else if (pick == 2 && p > 0 && tracker.unwritten(n) < n - tracker.loads_seen) begin
                idx = LIST_W'(order[$urandom_range(0, p - 1)]);
                send_word(OP_LOAD, idx, fresh_head(32'(idx)));
            end else begin
                if (tracker.unwritten(n) >= n - tracker.loads_seen) begin
                    for (j = p; j < n; j++) if (!tracker.written[order[j]]) break;
                    tmp = order[p];
                    order[p] = order[j];
                    order[j] = tmp;
                end
                idx = LIST_W'(order[p]);
                p++;
                send_word(OP_LOAD, idx, fresh_head(32'(idx)));
            end
        end
        while (tracker.heap_slots[0].val != 0) begin
            if ($urandom_range(0, 19) == 0) v = VAL_W'($urandom_range(0, 32'h7FFF_FFFF));
            else v = next_in_list(32'(tracker.heap_slots[0].src));
            send_word(OP_REFILL, LIST_W'($urandom_range(0, LISTS - 1)), v);
        end
        // Refill after the merge is done.
        send_word(OP_REFILL, LIST_W'($urandom_range(0, LISTS - 1)), '0);
    endtask

    initial begin : stimulus
        logic [APB_DW-1:0] rd;
        int unsigned       phase_start;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        apb_access(1'b0, '0, rd);
        if (rd !== {{(APB_DW - CFG_W){1'b0}}, ACTIVE_RESET})
            tracker.flag_mismatch($sformatf("active_lists reads %0d after reset", rd));

        configure(7'd4);
        // Ignored load past the active count, then a first run with a tie at the bottom.
        send_word(OP_LOAD,   6'd63, 31'h7FFF_FFFF);
        send_word(OP_LOAD,   6'd0,  31'd5);
        send_word(OP_LOAD,   6'd1,  31'h7FFF_FFFF);
        send_word(OP_LOAD,   6'd2,  31'd9);
        send_word(OP_LOAD,   6'd3,  31'd9);
        send_word(OP_REFILL, 6'd63, 31'h7FFF_FFFE);
        send_word(OP_REFILL, 6'd0,  31'd0);
        send_word(OP_REFILL, 6'd0,  31'd9);
        send_word(OP_REFILL, 6'd0,  31'd0);
        send_word(OP_REFILL, 6'd0,  31'd1);
        send_word(OP_REFILL, 6'd0,  31'd0);
        send_word(OP_REFILL, 6'd0,  31'd0);
        send_word(OP_REFILL, 6'd0,  31'd0);
        send_word(OP_REFILL, 6'd0,  31'd0);
        // Second run: refill in the middle of loading and a slot loaded twice.
        send_word(OP_LOAD,   6'd3,  31'd2);
        send_word(OP_REFILL, 6'd0,  31'h4000_0000);
        send_word(OP_LOAD,   6'd3,  31'd6);
        send_word(OP_LOAD,   6'd0,  31'h2AAA_AAAA);
        send_word(OP_LOAD,   6'd1,  31'h5555_5555);
        send_word(OP_REFILL, 6'd0,  31'd0);
        send_word(OP_REFILL, 6'd0,  31'd0);
        send_word(OP_REFILL, 6'd0,  31'd0);
        send_word(OP_REFILL, 6'd0,  31'd0);

        for (int ph = 0; ph < PLAN_LEN; ph++) begin
            configure(ACTIVE_PLAN[ph]);
            if (ph == 0) hold_off_req = 1'b1;
            phase_start = word_count;
            while (word_count - phase_start < PHASE_WORDS) merge_run();
        end

        drain_block();
        if (tracker.mismatch_count == 0)
            $display("** kway_merge_quaternary_heap: PASSED **");
        else
            $display("** kway_merge_quaternary_heap: FAILED **");
        $finish;
    end

endmodule
